// File: hdl/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Shared constants, types and the final decision function of the bond-angle
// structure classifier.
// ----------------------------------------------------------------------------
package bac_pkg;

  localparam int COORD_BITS_DEF     = 24;
  localparam int MAX_NEIGHBOURS_DEF = 14;

  localparam int DIG_W     = 8;   // multiplier digit per cycle
  localparam int CHI_W     = 7;   // histogram bin counter width
  localparam int CONST_W   = 20;  // width of squared edge constants
  localparam int MIN_NEIGH = 6;

  localparam int K145        = 145;
  localparam int K155        = 155;
  localparam int K600        = 600;
  localparam int ONE_MILLION = 1000000;

  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_FCC   = 3'd1;
  localparam logic [2:0] CLS_HCP   = 3'd2;
  localparam logic [2:0] CLS_BCC   = 3'd3;
  localparam logic [2:0] CLS_ICO   = 3'd4;

  typedef logic [7:0][CHI_W-1:0] chi_t;

  // squared cosine bin edges, in millionths
  function automatic logic [CONST_W-1:0] edge_sq(input logic [2:0] e);
    logic [CONST_W-1:0] v;
    case (e)
      3'd0:    v = CONST_W'(893025);
      3'd1:    v = CONST_W'(837225);
      3'd2:    v = CONST_W'(570025);
      3'd3:    v = CONST_W'(38025);
      3'd4:    v = CONST_W'(38025);
      3'd5:    v = CONST_W'(60025);
      3'd6:    v = CONST_W'(632025);
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic int iabs(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic [2:0] classify_fn(input chi_t chi, input logic [4:0] n1,
                                             input logic [3:0] mask);
    int c [8];
    int den;
    int fv;
    int hv;
    int n;
    logic bcc;
    logic [2:0] cls;
    for (int i = 0; i < 8; i++) begin
      c[i] = int'(chi[i]);
    end
    n   = int'(n1);
    den = c[5] + c[6] - c[4];
    if (c[0] == 7) begin
      bcc = 1'b1;
    end else if (den == 0) begin
      bcc = 1'b0;
    end else if (den < 0) begin
      bcc = 1'b1;
    end else begin
      bcc = (840 * c[4]) <= (100 * den * iabs(24 - c[6]));
    end
    fv = 122 * (iabs(c[0] + c[1] - 6) + c[2]);
    hv = 100 * (iabs(c[0] - 3) + iabs(c[0] + c[1] + c[2] + c[3] - 9));
    if (c[0] == 6) begin
      fv = 0;
    end else if (c[0] <= 3) begin
      hv = 0;
    end
    if (c[7] > 0) begin
      cls = CLS_OTHER;
    end else if (c[4] < 3) begin
      cls = (mask[3] && n >= 11 && n <= 13) ? CLS_ICO : CLS_OTHER;
    end else if (bcc) begin
      cls = (mask[2] && n >= 11) ? CLS_BCC : CLS_OTHER;
    end else if (n > 12 || n < 11) begin
      cls = CLS_OTHER;
    end else if (fv < hv) begin
      cls = mask[0] ? CLS_FCC : CLS_OTHER;
    end else begin
      cls = mask[1] ? CLS_HCP : CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// File: hdl/bac_in_if.sv
// ----------------------------------------------------------------------------
// bac_in_if
// Neighbour request channel: valid/ready with offset vector and flags.
// ----------------------------------------------------------------------------
interface bac_in_if import bac_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] offset_x;
  logic signed [COORD_BITS-1:0] offset_y;
  logic signed [COORD_BITS-1:0] offset_z;
  logic                         present;
  logic                         last;

  modport source (output valid, offset_x, offset_y, offset_z, present, last, input ready);
  modport sink   (input valid, offset_x, offset_y, offset_z, present, last, output ready);
endinterface

// File: hdl/bac_out_if.sv
// ----------------------------------------------------------------------------
// bac_out_if
// Result request channel: valid/ready with the structure class.
// ----------------------------------------------------------------------------
interface bac_out_if ();
  logic       valid;
  logic       ready;
  logic [2:0] structure;

  modport source (output valid, structure, input ready);
  modport sink   (input valid, structure, output ready);
endinterface

// File: hdl/bac_store.sv
// ----------------------------------------------------------------------------
// bac_store
// Neighbour store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bac_store import bac_pkg::*; #(
  parameter int DEPTH = MAX_NEIGHBOURS_DEF,
  parameter int WIDTH = 5 * COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/bac_mul.sv
// ----------------------------------------------------------------------------
// bac_mul
// Shared unsigned multiplier, one 8-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module bac_mul import bac_pkg::*; #(
  parameter int PW = 4 * COORD_BITS_DEF + CONST_W,
  parameter int BW = 2 * COORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [PW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [PW-1:0] p
);

  localparam int NC  = (BW + DIG_W - 1) / DIG_W;
  localparam int NCW = (NC > 1) ? $clog2(NC) : 1;

  logic [PW-1:0]  a_r;
  logic [BW-1:0]  b_r;
  logic [PW-1:0]  acc_r;
  logic [NCW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NCW'(1);
        if (cnt_r == NCW'(NC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + PW'(a_r * b_r[DIG_W-1:0]);
      a_r   <= a_r << DIG_W;
      b_r   <= b_r >> DIG_W;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// File: hdl/bond_angle_structure_classifier_unit.sv
// ----------------------------------------------------------------------------
// bond_angle_structure_classifier_unit
// Takes the nearest neighbours of one particle (nearest first, up to
// MAX_NEIGHBOURS) and answers with its structure class: other, fcc, hcp,
// bcc or ico. For each present neighbour request one shared signed
// multiplier forms the squared length, then the store is written. On the
// last request the block classifies: the mean length and the n0/n1 scan,
// then for every pair among the n0 nearest the dot product and 1 to 4 bin
// edge tests in the 8-bit-per-cycle shared multiplier. No request is taken
// while a particle is being classified or while its result waits for the
// output register to free up; a result already in the output register does
// not block new requests.
// ----------------------------------------------------------------------------
module bond_angle_structure_classifier_unit import bac_pkg::*; #(
  parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
  parameter int COORD_BITS     = COORD_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  bac_in_if.sink     in_req,
  bac_out_if.source  out_req
);

  localparam int CB = COORD_BITS;
  localparam int LW = 2 * CB;             // squared length / dot magnitude
  localparam int SW = LW + 3;             // sum of six lengths
  localparam int TW = SW + 8;             // scaled thresholds
  localparam int QW = 4 * CB;             // products of two lengths
  localparam int PW = QW + CONST_W;
  localparam int BW = LW;
  localparam int CW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int AW = $clog2(MAX_NEIGHBOURS);
  localparam int MW = 5 * CB;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQ    = 5'd1;
  localparam logic [4:0] S_WR    = 5'd2;
  localparam logic [4:0] S_CL0   = 5'd3;
  localparam logic [4:0] S_SUMRD = 5'd4;
  localparam logic [4:0] S_SUMEV = 5'd5;
  localparam logic [4:0] S_THR   = 5'd6;
  localparam logic [4:0] S_SCRD  = 5'd7;
  localparam logic [4:0] S_SCEV  = 5'd8;
  localparam logic [4:0] S_PJ    = 5'd9;
  localparam logic [4:0] S_PJL   = 5'd10;
  localparam logic [4:0] S_PK    = 5'd11;
  localparam logic [4:0] S_PKL   = 5'd12;
  localparam logic [4:0] S_DOT   = 5'd13;
  localparam logic [4:0] S_MS    = 5'd14;
  localparam logic [4:0] S_MW    = 5'd15;
  localparam logic [4:0] S_NX    = 5'd16;
  localparam logic [4:0] S_DEC   = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;

  localparam logic [1:0] MPH_P    = 2'd0;
  localparam logic [1:0] MPH_SQ   = 2'd1;
  localparam logic [1:0] MPH_A6   = 2'd2;
  localparam logic [1:0] MPH_EDGE = 2'd3;

  logic [4:0]           state_r;
  logic [CW-1:0]        cnt_r;
  logic signed [CB-1:0] x_r, y_r, z_r;
  logic                 present_r, last_r;
  logic [1:0]           step_r;
  logic [LW-1:0]        len_r;
  logic [3:0]           mask_r;
  logic [CW-1:0]        i_r;
  logic [SW-1:0]        s_r;
  logic [TW-1:0]        t145_r, t155_r;
  logic [CW-1:0]        n0_r, n1_r, j_r, k_r;
  logic                 c0_r, c1_r;
  logic signed [CB-1:0] xj_r, yj_r, zj_r;
  logic [LW-1:0]        lj_r;
  logic signed [LW:0]   dot_r;
  logic [1:0]           mph_r;
  logic [QW-1:0]        p_r, sq_r;
  logic [PW-1:0]        a6_r;
  logic [2:0]           e_r, bin_r;
  chi_t                 chi_r;
  logic [2:0]           res_r;
  logic                 out_valid_r;
  logic [2:0]           out_struct_r;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr;
  logic [MW-1:0]        rd_data;
  logic signed [CB-1:0] rd_x, rd_y, rd_z;
  logic [LW-1:0]        rd_len;

  logic signed [CB-1:0] ma, mb;
  logic signed [LW-1:0] mprod;
  logic                 dot_neg;
  logic [LW:0]          dot_abs;
  logic [LW-1:0]        dot_mag;
  logic [TW-1:0]        l600;

  logic                 mul_start, mul_done;
  logic [PW-1:0]        mul_a, mul_p;
  logic [BW-1:0]        mul_b;

  logic                 in_acc, out_load;
  logic                 edge_ok, edge_last;
  logic [2:0]           bin_fin;

  assign in_acc   = in_req.valid && in_req.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_req.ready);

  assign in_req.ready      = (state_r == S_IDLE);
  assign out_req.valid     = out_valid_r;
  assign out_req.structure = out_struct_r;

  assign rd_len = rd_data[LW-1:0];
  assign rd_z   = $signed(rd_data[3*CB-1:2*CB]);
  assign rd_y   = $signed(rd_data[4*CB-1:3*CB]);
  assign rd_x   = $signed(rd_data[5*CB-1:4*CB]);

  assign dot_neg = dot_r[LW];
  assign dot_abs = dot_neg ? -dot_r : dot_r;
  assign dot_mag = dot_abs[LW-1:0];
  assign l600    = TW'(rd_len) * TW'(K600);

  // shared signed multiplier: squared length on ingest, dot product on pairs
  always_comb begin
    case (state_r)
      S_SQ: begin
        case (step_r)
          2'd0:    ma = x_r;
          2'd1:    ma = y_r;
          default: ma = z_r;
        endcase
        mb = ma;
      end
      default: begin
        case (step_r)
          2'd0:    begin ma = xj_r; mb = rd_x; end
          2'd1:    begin ma = yj_r; mb = rd_y; end
          default: begin ma = zj_r; mb = rd_z; end
        endcase
      end
    endcase
  end
  assign mprod = ma * mb;

  always_comb begin
    case (mph_r)
      MPH_P:    begin mul_a = PW'(lj_r);    mul_b = BW'(rd_len);           end
      MPH_SQ:   begin mul_a = PW'(dot_mag); mul_b = BW'(dot_mag);          end
      MPH_A6:   begin mul_a = PW'(sq_r);    mul_b = BW'(ONE_MILLION);      end
      default:  begin mul_a = PW'(p_r);     mul_b = BW'(edge_sq(e_r));     end
    endcase
  end
  assign mul_start = (state_r == S_MS);

  assign edge_ok   = dot_neg ? (a6_r <= mul_p) : (a6_r >= mul_p);
  assign edge_last = dot_neg ? (e_r == 3'd3) : (e_r == 3'd6);
  assign bin_fin   = edge_ok ? (e_r + 3'd1) : bin_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i_r[AW-1:0];
    case (state_r)
      S_SUMRD, S_SCRD: rd_en = 1'b1;
      S_PJ: begin
        rd_en   = (j_r + CW'(1)) < n0_r;
        rd_addr = j_r[AW-1:0];
      end
      S_PK: begin
        rd_en   = 1'b1;
        rd_addr = k_r[AW-1:0];
      end
      default: rd_en = 1'b0;
    endcase
  end
  assign wr_en = (state_r == S_WR);

  bac_store #(
    .DEPTH (MAX_NEIGHBOURS),
    .WIDTH (MW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({x_r, y_r, z_r, len_r}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bac_mul #(
    .PW (PW),
    .BW (BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= 4'hF;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      mph_r       <= MPH_P;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_req.present && cnt_r < CW'(MAX_NEIGHBOURS)) begin
              step_r  <= '0;
              state_r <= S_SQ;
            end else if (in_req.last) begin
              state_r <= S_CL0;
            end
          end
        end
        S_SQ: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          cnt_r   <= cnt_r + CW'(1);
          state_r <= last_r ? S_CL0 : S_IDLE;
        end
        S_CL0: begin
          state_r <= (cnt_r < CW'(MIN_NEIGH)) ? S_OUT : S_SUMRD;
        end
        S_SUMRD: state_r <= S_SUMEV;
        S_SUMEV: state_r <= (i_r == CW'(MIN_NEIGH - 1)) ? S_THR : S_SUMRD;
        S_THR:   state_r <= S_SCRD;
        S_SCRD:  state_r <= S_SCEV;
        S_SCEV:  state_r <= ((i_r + CW'(1)) == cnt_r) ? S_PJ : S_SCRD;
        S_PJ:    state_r <= ((j_r + CW'(1)) < n0_r) ? S_PJL : S_DEC;
        S_PJL:   state_r <= S_PK;
        S_PK:    state_r <= S_PKL;
        S_PKL: begin
          step_r  <= '0;
          state_r <= (lj_r == '0 || rd_len == '0) ? S_NX : S_DOT;
        end
        S_DOT: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd2) begin
            mph_r   <= MPH_P;
            state_r <= S_MS;
          end
        end
        S_MS: state_r <= S_MW;
        S_MW: begin
          if (mul_done) begin
            case (mph_r)
              MPH_P:  begin mph_r <= MPH_SQ;   state_r <= S_MS; end
              MPH_SQ: begin mph_r <= MPH_A6;   state_r <= S_MS; end
              MPH_A6: begin mph_r <= MPH_EDGE; state_r <= S_MS; end
              default: state_r <= (edge_ok && !edge_last) ? S_MS : S_NX;
            endcase
          end
        end
        S_NX:  state_r <= ((k_r + CW'(1)) < n0_r) ? S_PK : S_PJ;
        S_DEC: state_r <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r       <= in_req.offset_x;
        y_r       <= in_req.offset_y;
        z_r       <= in_req.offset_z;
        present_r <= in_req.present;
        last_r    <= in_req.last;
      end
      S_SQ: begin
        len_r <= ((step_r == 2'd0) ? '0 : len_r) + $unsigned(mprod);
      end
      S_CL0: begin
        i_r   <= '0;
        s_r   <= '0;
        chi_r <= '0;
        res_r <= CLS_OTHER;
      end
      S_SUMEV: begin
        s_r <= s_r + SW'(rd_len);
        i_r <= i_r + CW'(1);
      end
      S_THR: begin
        t145_r <= TW'(s_r) * TW'(K145);
        t155_r <= TW'(s_r) * TW'(K155);
        i_r    <= '0;
        n0_r   <= '0;
        n1_r   <= '0;
        c0_r   <= 1'b1;
        c1_r   <= 1'b1;
        j_r    <= '0;
      end
      S_SCEV: begin
        i_r <= i_r + CW'(1);
        if (c0_r && l600 <= t145_r) begin
          n0_r <= n0_r + CW'(1);
          n1_r <= n1_r + CW'(1);
        end else if (c1_r) begin
          c0_r <= 1'b0;
          if (l600 < t155_r) begin
            n1_r <= n1_r + CW'(1);
          end else begin
            c1_r <= 1'b0;
          end
        end else begin
          c0_r <= 1'b0;
        end
      end
      S_PJL: begin
        xj_r <= rd_x;
        yj_r <= rd_y;
        zj_r <= rd_z;
        lj_r <= rd_len;
        k_r  <= j_r + CW'(1);
      end
      S_DOT: begin
        dot_r <= ((step_r == 2'd0) ? '0 : dot_r) + {mprod[LW-1], mprod};
      end
      S_MW: begin
        if (mul_done) begin
          case (mph_r)
            MPH_P:  p_r  <= mul_p[QW-1:0];
            MPH_SQ: sq_r <= mul_p[QW-1:0];
            MPH_A6: begin
              a6_r  <= mul_p;
              e_r   <= dot_neg ? 3'd0 : 3'd4;
              bin_r <= dot_neg ? 3'd0 : 3'd4;
            end
            default: begin
              bin_r <= bin_fin;
              e_r   <= e_r + 3'd1;
              if (!(edge_ok && !edge_last)) begin
                chi_r[bin_fin] <= chi_r[bin_fin] + CHI_W'(1);
              end
            end
          endcase
        end
      end
      S_NX: begin
        if ((k_r + CW'(1)) < n0_r) begin
          k_r <= k_r + CW'(1);
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
      S_DEC: res_r <= classify_fn(chi_r, 5'(n1_r), mask_r);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_struct_r <= res_r;
    end
  end

  // a present neighbour request is the only way into the squaring step
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ && step_r == 2'd0) |-> present_r)
    else $error("squaring without a present neighbour");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_NEIGHBOURS))
    else $error("neighbour count overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MS) |-> (n1_r >= n0_r && k_r > j_r && k_r < n0_r))
    else $error("pair indices out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_struct_r <= CLS_ICO && state_r == S_IDLE))
    else $error("bad result code");

endmodule
